// File: rtl/core/fdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_pkg
// Widths and types shared by the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;
  localparam int VEC_W   = 16;
  localparam int IDX_W   = 15;
  localparam int RFB     = 16;                 // result fraction bits
  localparam int REFL_W  = RFB + 1;
  localparam int DOT_W   = 34;                 // sum of three 16x16 products
  localparam int PROD_W  = DOT_W + IDX_W + 1;  // 50, signed
  localparam int SUM_W   = PROD_W + 1;         // 51, signed
  localparam int MAG_W   = SUM_W;              // magnitude of a sum
  localparam int Q_W     = RFB + 2;            // quotient incl. integer bits
  localparam int DIV_STEPS = RFB + 1;          // one quotient bit per stage
  localparam int REM_W   = MAG_W + 1;

  typedef struct packed {
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic             big;
  } div_lane_t;
endpackage
`default_nettype wire

// File: rtl/core/fresnel_dielectric_reflectance.sv
// Pipeline from input transfer to result: products, dot, index products,
// sums, 17 restoring-divider stages, square, sum and clamp stages.
// Throughput: one item per cycle; all stages hold when a valid result stalls.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_normal_x,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_normal_y,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_normal_z,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_incident_x,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_incident_y,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_incident_z,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_transmitted_x,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_transmitted_y,
  input  wire logic signed [fdr_pkg::VEC_W-1:0]    in_transmitted_z,
  input  wire logic [fdr_pkg::IDX_W-1:0]           in_index_incident,
  input  wire logic [fdr_pkg::IDX_W-1:0]           in_index_transmitted,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [fdr_pkg::REFL_W-1:0]               out_reflectance,
  output logic                                     out_zero_denominator,
  output logic                                     out_saturated
);
  localparam int NDIV = fdr_pkg::DIV_STEPS;
  localparam int S2W = 2 * fdr_pkg::Q_W;

  // A stage advances whenever the output side is not holding.
  logic adv;
  assign adv      = !out_stall || !out_valid;
  assign in_stall = !adv;

  // Stage 1: six products.
  logic v1_r;
  logic signed [2*fdr_pkg::VEC_W-1:0] pi_r [3];
  logic signed [2*fdr_pkg::VEC_W-1:0] pt_r [3];
  logic [fdr_pkg::IDX_W-1:0] ei1_r, eo1_r;
  // Stage 2: dot products.
  logic v2_r;
  logic signed [fdr_pkg::DOT_W-1:0] ci_r, co_r;
  logic [fdr_pkg::IDX_W-1:0] ei2_r, eo2_r;
  // Stage 3: index products.
  logic v3_r;
  logic signed [fdr_pkg::PROD_W-1:0] eoci_r, eico_r, eici_r, eoco_r;
  // Stage 4: numerators, denominators, magnitudes.
  logic v4_r, zero4_r;
  fdr_pkg::div_lane_t l4_r [2];
  // Divider stages.
  logic v_d_r [NDIV];
  logic z_d_r [NDIV];
  fdr_pkg::div_lane_t l_d_r [NDIV][2];
  // Squares, sum, clamp.
  logic v5_r, z5_r;
  logic [S2W-1:0] s1_r, s2_r;
  logic v6_r, z6_r;
  logic [S2W-1:0] half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; out_valid <= 1'b0;
      for (int k = 0; k < NDIV; k++) v_d_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v_d_r[0] <= v4_r;
      for (int k = 1; k < NDIV; k++) v_d_r[k] <= v_d_r[k-1];
      v5_r <= v_d_r[NDIV-1]; v6_r <= v5_r; out_valid <= v6_r;
    end
  end

  // Divider combinational step per stage.
  function automatic fdr_pkg::div_lane_t div_step(input fdr_pkg::div_lane_t a,
                                                  input logic first);
    fdr_pkg::div_lane_t b;
    logic [fdr_pkg::REM_W-1:0] r;
    logic [fdr_pkg::REM_W-1:0] d;
    b = a;
    d = {1'b0, a.den};
    r = first ? {1'b0, a.num} : {a.rem[fdr_pkg::REM_W-2:0], 1'b0};
    b.q = {a.q[fdr_pkg::Q_W-2:0], 1'b0};
    if (r >= d) begin
      r = r - d;
      b.q[0] = 1'b1;
    end
    b.rem = r;
    return b;
  endfunction

  function automatic fdr_pkg::div_lane_t mk_lane(
      input logic signed [fdr_pkg::SUM_W-1:0] n,
      input logic signed [fdr_pkg::SUM_W-1:0] d);
    fdr_pkg::div_lane_t l;
    logic [fdr_pkg::REM_W-1:0] num_ext, den_ext;
    l.num = n[fdr_pkg::SUM_W-1] ? fdr_pkg::MAG_W'(-n) : fdr_pkg::MAG_W'(n);
    l.den = d[fdr_pkg::SUM_W-1] ? fdr_pkg::MAG_W'(-d) : fdr_pkg::MAG_W'(d);
    num_ext = {1'b0, l.num};
    den_ext = {l.den, 1'b0};
    l.big = (num_ext >= den_ext);
    l.rem = '0;
    l.q = '0;
    return l;
  endfunction

  logic signed [fdr_pkg::SUM_W-1:0] n1, d1, n2, d2;
  assign n1 = fdr_pkg::SUM_W'(eoci_r) - fdr_pkg::SUM_W'(eico_r);
  assign d1 = fdr_pkg::SUM_W'(eoci_r) + fdr_pkg::SUM_W'(eico_r);
  assign n2 = fdr_pkg::SUM_W'(eici_r) - fdr_pkg::SUM_W'(eoco_r);
  assign d2 = fdr_pkg::SUM_W'(eici_r) + fdr_pkg::SUM_W'(eoco_r);

  logic [fdr_pkg::Q_W-1:0] qf [2];
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      qf[j] = l_d_r[NDIV-1][j].big ? {1'b0, {(fdr_pkg::Q_W-1){1'b1}}}
                                   : l_d_r[NDIV-1][j].q;
    end
  end

  localparam logic [S2W-1:0] ONE_S = S2W'(1) << (2 * fdr_pkg::RFB);
  logic [S2W-1:0] half_nxt;
  assign half_nxt = (s1_r >> 1) + (s2_r >> 1) + S2W'(s1_r[0] & s2_r[0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      pi_r[0] <= in_normal_x * in_incident_x;
      pi_r[1] <= in_normal_y * in_incident_y;
      pi_r[2] <= in_normal_z * in_incident_z;
      pt_r[0] <= in_normal_x * in_transmitted_x;
      pt_r[1] <= in_normal_y * in_transmitted_y;
      pt_r[2] <= in_normal_z * in_transmitted_z;
      ei1_r <= in_index_incident;
      eo1_r <= in_index_transmitted;

      ci_r <= fdr_pkg::DOT_W'(pi_r[0]) + fdr_pkg::DOT_W'(pi_r[1])
            + fdr_pkg::DOT_W'(pi_r[2]);
      co_r <= -(fdr_pkg::DOT_W'(pt_r[0]) + fdr_pkg::DOT_W'(pt_r[1])
            + fdr_pkg::DOT_W'(pt_r[2]));
      ei2_r <= ei1_r;
      eo2_r <= eo1_r;

      // Products are formed at the full register width.
      eoci_r <= $signed({1'b0, eo2_r}) * ci_r;
      eico_r <= $signed({1'b0, ei2_r}) * co_r;
      eici_r <= $signed({1'b0, ei2_r}) * ci_r;
      eoco_r <= $signed({1'b0, eo2_r}) * co_r;

      zero4_r <= (d1 == '0) || (d2 == '0);
      l4_r[0] <= mk_lane(n1, d1);
      l4_r[1] <= mk_lane(n2, d2);

      z_d_r[0] <= zero4_r;
      l_d_r[0][0] <= div_step(l4_r[0], 1'b1);
      l_d_r[0][1] <= div_step(l4_r[1], 1'b1);
      for (int k = 1; k < NDIV; k++) begin
        z_d_r[k] <= z_d_r[k-1];
        l_d_r[k][0] <= div_step(l_d_r[k-1][0], 1'b0);
        l_d_r[k][1] <= div_step(l_d_r[k-1][1], 1'b0);
      end

      z5_r <= z_d_r[NDIV-1];
      s1_r <= qf[0] * qf[0];
      s2_r <= qf[1] * qf[1];

      z6_r <= z5_r;
      half_r <= half_nxt;

      out_zero_denominator <= z6_r;
      if (z6_r) begin
        out_reflectance <= fdr_pkg::REFL_W'(1) << fdr_pkg::RFB;
        out_saturated <= 1'b0;
      end else if (half_r >= ONE_S + (S2W'(1) << fdr_pkg::RFB)) begin
        out_reflectance <= fdr_pkg::REFL_W'(1) << fdr_pkg::RFB;
        out_saturated <= 1'b1;
      end else begin
        out_reflectance <= fdr_pkg::REFL_W'(half_r >> fdr_pkg::RFB);
        out_saturated <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/fdr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_checker
// Port-level assertions for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
module fdr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] out_reflectance,
  input wire logic        out_zero_denominator,
  input wire logic        out_saturated
);
  // The input only stalls when a result is held at the output.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("input stall without hold");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_zero_denominator && out_saturated)) else $error("both flags");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reflectance <= 17'h10000)) else $error("reflectance range");
  a_flag1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_zero_denominator || out_saturated)) |->
      (out_reflectance == 17'h10000)) else $error("flag without one");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reflectance)))
    else $error("held result changed");
endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_reflectance(out_reflectance),
  .out_zero_denominator(out_zero_denominator), .out_saturated(out_saturated)
);
`default_nettype wire

// File: verif/fresnel_dielectric_reflectance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_checker
// Watches both channels of the reflectance pipeline, predicts each result
// from the accepted input and compares it with what comes out, in order.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_normal_x,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_normal_y,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_normal_z,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_incident_x,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_incident_y,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_incident_z,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_transmitted_x,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_transmitted_y,
  input  wire logic signed [fdr_pkg::VEC_W-1:0] in_transmitted_z,
  input  wire logic [fdr_pkg::IDX_W-1:0]        in_index_incident,
  input  wire logic [fdr_pkg::IDX_W-1:0]        in_index_transmitted,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [fdr_pkg::REFL_W-1:0]       out_reflectance,
  input  wire logic                             out_zero_denominator,
  input  wire logic                             out_saturated,
  output int                                    mismatches,
  output int                                    pending,
  output int                                    results_seen,
  output int                                    sat_seen,
  output int                                    zero_seen
);
  typedef struct packed {
    logic [fdr_pkg::REFL_W-1:0] refl;
    logic                       zero_den;
    logic                       sat;
  } refl_result_t;

  refl_result_t expected_refl[$];

  // Restoring division, one quotient bit per step, clamped just under 2.0.
  function automatic longint unsigned amp_ratio(longint unsigned n, longint unsigned d);
    longint unsigned q, rem;
    if (n >= 2 * d) return (64'd1 << (fdr_pkg::RFB + 1)) - 1;
    rem = n;
    q = 0;
    if (rem >= d) begin
      rem -= d;
      q = 1;
    end
    for (int i = 0; i < fdr_pkg::RFB; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= d) begin
        rem -= d;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic refl_result_t fresnel(
      longint nx, longint ny, longint nz, longint ix, longint iy, longint iz,
      longint tx, longint ty, longint tz, longint ei, longint eo);
    refl_result_t r;
    longint ci, co, num1, den1, num2, den2;
    longint unsigned q1, q2, s1, s2, half, refl;
    ci = nx * ix + ny * iy + nz * iz;
    co = -(nx * tx + ny * ty + nz * tz);
    num1 = eo * ci - ei * co;
    den1 = eo * ci + ei * co;
    num2 = ei * ci - eo * co;
    den2 = ei * ci + eo * co;
    r = '0;
    if (den1 == 0 || den2 == 0) begin
      r.refl = fdr_pkg::REFL_W'(1) << fdr_pkg::RFB;
      r.zero_den = 1'b1;
    end else begin
      q1 = amp_ratio(mag(num1), mag(den1));
      q2 = amp_ratio(mag(num2), mag(den2));
      s1 = q1 * q1;
      s2 = q2 * q2;
      half = (s1 >> 1) + (s2 >> 1) + (s1 & s2 & 1);
      refl = half >> fdr_pkg::RFB;
      if (refl > (64'd1 << fdr_pkg::RFB)) begin
        refl = 64'd1 << fdr_pkg::RFB;
        r.sat = 1'b1;
      end
      r.refl = refl[fdr_pkg::REFL_W-1:0];
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    results_seen = 0;
    sat_seen = 0;
    zero_seen = 0;
  end

  always @(posedge clk) begin
    refl_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_refl.push_back(fresnel(in_normal_x, in_normal_y, in_normal_z,
            in_incident_x, in_incident_y, in_incident_z,
            in_transmitted_x, in_transmitted_y, in_transmitted_z,
            longint'(in_index_incident), longint'(in_index_transmitted)));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_saturated) sat_seen++;
        if (out_zero_denominator) zero_seen++;
        if (expected_refl.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result transfer refl=%0d", out_reflectance);
        end else begin
          want = expected_refl.pop_front();
          if (out_reflectance !== want.refl || out_zero_denominator !== want.zero_den ||
              out_saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d exp refl=%0d zd=%0b sat=%0b got refl=%0d zd=%0b sat=%0b",
                       results_seen, want.refl, want.zero_den, want.sat,
                       out_reflectance, out_zero_denominator, out_saturated);
          end
        end
      end
      pending = expected_refl.size();
    end
  end
endmodule

// File: verif/fresnel_dielectric_reflectance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_tb
// Drives directed and random ray hits into the reflectance pipeline with
// bursty input and random output stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_tb;
  localparam int RANDOM_HITS = 800;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [8:0][fdr_pkg::VEC_W-1:0] v;   // n, wi, wo components
    logic [fdr_pkg::IDX_W-1:0]      ei;
    logic [fdr_pkg::IDX_W-1:0]      eo;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [fdr_pkg::VEC_W-1:0] vec_in[9];
  logic [fdr_pkg::IDX_W-1:0] in_index_incident = '0;
  logic [fdr_pkg::IDX_W-1:0] in_index_transmitted = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fdr_pkg::REFL_W-1:0] out_reflectance;
  logic out_zero_denominator;
  logic out_saturated;

  int mismatches, pending, results_seen, sat_seen, zero_seen;
  int hits_sent = 0;
  int burst_left = 0;
  bit long_hold_go = 1'b0;

  initial for (int i = 0; i < 9; i++) vec_in[i] = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  fresnel_dielectric_reflectance u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_normal_x(vec_in[0]), .in_normal_y(vec_in[1]), .in_normal_z(vec_in[2]),
    .in_incident_x(vec_in[3]), .in_incident_y(vec_in[4]), .in_incident_z(vec_in[5]),
    .in_transmitted_x(vec_in[6]), .in_transmitted_y(vec_in[7]),
    .in_transmitted_z(vec_in[8]),
    .in_index_incident(in_index_incident), .in_index_transmitted(in_index_transmitted),
    .out_valid(out_valid), .out_stall(out_stall), .out_reflectance(out_reflectance),
    .out_zero_denominator(out_zero_denominator), .out_saturated(out_saturated)
  );

  fresnel_dielectric_reflectance_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_normal_x(vec_in[0]), .in_normal_y(vec_in[1]), .in_normal_z(vec_in[2]),
    .in_incident_x(vec_in[3]), .in_incident_y(vec_in[4]), .in_incident_z(vec_in[5]),
    .in_transmitted_x(vec_in[6]), .in_transmitted_y(vec_in[7]),
    .in_transmitted_z(vec_in[8]),
    .in_index_incident(in_index_incident), .in_index_transmitted(in_index_transmitted),
    .out_valid(out_valid), .out_stall(out_stall), .out_reflectance(out_reflectance),
    .out_zero_denominator(out_zero_denominator), .out_saturated(out_saturated),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
    .sat_seen(sat_seen), .zero_seen(zero_seen)
  );

  // Receiver: stall density switches among four random modes, plus one long hold-off.
  initial begin
    int mode, cyc, hold_left;
    bit hold_done;
    mode = 0;
    cyc = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (long_hold_go && !hold_done) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("fresnel_dielectric_reflectance verification failed");
    $finish;
  end

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
  endtask

  // Offers one hit and returns at the edge where it transfers.
  task automatic send_hit(hit_t h);
    bit stalled;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) vec_in[i] <= h.v[8-i];
    in_index_incident <= h.ei;
    in_index_transmitted <= h.eo;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    hits_sent++;
  endtask

  function automatic hit_t mk(int nx, int ny, int nz, int ix, int iy, int iz,
                              int tx, int ty, int tz, int ei, int eo);
    hit_t h;
    h.v = {16'(nx), 16'(ny), 16'(nz), 16'(ix), 16'(iy), 16'(iz),
           16'(tx), 16'(ty), 16'(tz)};
    h.ei = 15'(ei);
    h.eo = 15'(eo);
    return h;
  endfunction

  function automatic int comp();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  // Mostly physically sensible hits: normal on an axis-ish direction, wi on
  // the same side, wo across the boundary, indices near glass and air.
  function automatic hit_t random_hit();
    hit_t h;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      for (int i = 0; i < 9; i++) h.v[i] = 16'($urandom);
      h.ei = 15'($urandom);
      h.eo = 15'($urandom);
    end else if (sel < 3) begin
      h = mk(comp(), comp(), comp(), comp(), comp(), comp(), comp(), comp(), comp(),
             $urandom_range(0, 32767), $urandom_range(0, 32767));
    end else begin
      h = mk(0, 0, 16384, comp() / 2, comp() / 2, $urandom_range(1, 16384),
             comp() / 2, comp() / 2, -$urandom_range(0, 16384),
             $urandom_range(7000, 20000), $urandom_range(7000, 20000));
      if (sel == 9) h.eo = h.ei;
    end
    return h;
  endfunction

  initial begin
    hit_t directed[$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All zero vectors give zero denominators.
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 8192, 12288));
    // Normal incidence, equal indices: no reflection.
    directed.push_back(mk(16384, 0, 0, 16384, 0, 0, -16384, 0, 0, 8192, 8192));
    // Normal incidence, air to glass and glass to air.
    directed.push_back(mk(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 8192, 12288));
    directed.push_back(mk(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 12288, 8192));
    // Index extremes, including zero.
    directed.push_back(mk(0, 16384, 0, 0, 16384, 0, 0, -16384, 0, 1, 32767));
    directed.push_back(mk(0, 16384, 0, 0, 16384, 0, 0, -16384, 0, 32767, 1));
    directed.push_back(mk(0, 16384, 0, 0, 16384, 0, 0, -16384, 0, 0, 8192));
    directed.push_back(mk(0, 16384, 0, 0, 16384, 0, 0, -16384, 0, 32767, 32767));
    // Most negative components everywhere.
    directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, 32767, 32767));
    directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                          -32768, -32768, -32768, 32767, 1));
    directed.push_back(mk(-16384, -16384, -16384, 16384, 16384, 16384,
                          16384, 16384, 16384, 8192, 16384));
    // Near-cancelling denominator: a large ratio that saturates.
    directed.push_back(mk(16384, 0, 0, 16384, 0, 0, 16383, 0, 0, 8192, 8193));
    directed.push_back(mk(16384, 0, 0, 100, 0, 0, 99, 0, 0, 8192, 8192));
    // Grazing incidence and a transmitted direction on the same side.
    directed.push_back(mk(0, 0, 16384, 16384, 0, 1, 16384, 0, -8000, 8192, 12288));
    directed.push_back(mk(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 8192, 12288));
    directed.push_back(mk(0, 0, 16384, 0, 0, -16384, 0, 0, -16384, 12288, 8192));
    // Transmitted direction tangent to the surface: co = 0, no zero denominator.
    directed.push_back(mk(0, 0, 16384, 0, 0, 16384, 16384, 0, 0, 8192, 12288));
    foreach (directed[i]) send_hit(directed[i]);

    // Sender pause until the pipeline is empty.
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    for (int n = 0; n < RANDOM_HITS; n++) begin
      if (n == 300) long_hold_go = 1'b1;
      send_hit(random_hit());
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d hits, checked %0d results (%0d saturated, %0d zero denominator).",
             hits_sent, results_seen, sat_seen, zero_seen);
    $display("Input bursts, random output stalls and one long output hold-off were applied.");
    if (mismatches == 0 && pending == 0) begin
      $display("fresnel_dielectric_reflectance verification clean");
    end else begin
      $display("fresnel_dielectric_reflectance verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/fdr_pkg.sv
rtl/core/fresnel_dielectric_reflectance.sv
rtl/core/fdr_checker.sv
verif/fresnel_dielectric_reflectance_checker.sv
verif/fresnel_dielectric_reflectance_tb.sv
